[rtl/ams_pkg.sv]
package ams_pkg;

   localparam int WORD_BITS = 32;
   localparam int MEM_WORDS = 100;
   localparam int ADDR_BITS = 7;
   localparam int OP_BITS   = 6;
   localparam int CNT_BITS  = $clog2(WORD_BITS + 1);

   // instruction words that can carry a known opcode lie in this range
   localparam int DEC_LOW     = 1000;
   localparam int DEC_HIGH    = 4400;
   localparam int DEC_BITS    = 13;
   // word / 100 as (word * 1311) >> 17, exact over the decode range
   localparam int RECIP       = 1311;
   localparam int RECIP_BITS  = 11;
   localparam int RECIP_SHIFT = 17;
   localparam int DEC_RADIX   = 100;

   localparam logic [1:0] KIND_LOAD    = 2'd0;
   localparam logic [1:0] KIND_EXEC    = 2'd1;
   localparam logic [1:0] KIND_RESTART = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_UNKNOWN  = 2'd1;
   localparam logic [1:0] ST_DIV_ZERO = 2'd2;
   localparam logic [1:0] ST_HALTED   = 2'd3;

   localparam logic [OP_BITS-1:0] OP_READ   = 6'd10;
   localparam logic [OP_BITS-1:0] OP_WRITE  = 6'd11;
   localparam logic [OP_BITS-1:0] OP_LOAD   = 6'd20;
   localparam logic [OP_BITS-1:0] OP_STORE  = 6'd21;
   localparam logic [OP_BITS-1:0] OP_ADD    = 6'd30;
   localparam logic [OP_BITS-1:0] OP_SUB    = 6'd31;
   localparam logic [OP_BITS-1:0] OP_DIV    = 6'd32;
   localparam logic [OP_BITS-1:0] OP_MUL    = 6'd33;
   localparam logic [OP_BITS-1:0] OP_BRANCH = 6'd40;
   localparam logic [OP_BITS-1:0] OP_BRNEG  = 6'd41;
   localparam logic [OP_BITS-1:0] OP_BRZERO = 6'd42;
   localparam logic [OP_BITS-1:0] OP_HALT   = 6'd43;

   typedef struct packed {
      logic [1:0]           kind;
      logic [ADDR_BITS-1:0] load_address;
      logic signed [31:0]   load_word;
      logic signed [31:0]   input_value;
   } req_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] pc;
      logic signed [31:0]   acc_value;
      logic                 out_valid;
      logic signed [31:0]   out_value;
      logic                 input_used;
      logic                 halted;
      logic [1:0]           status;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic load_write;
      logic restart;
      logic ignore;
      logic rd_pc;
      logic rd_addr;
      logic decode;
      logic exec;
      logic mul_wb;
      logic div_start;
      logic div_wb;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       halted;
      logic       div_go;
      logic       mul_go;
      logic       div_done;
   } sts_type;

endpackage

[rtl/ams_div.sv]
module ams_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [ams_pkg::WORD_BITS-1:0] dividend,
   input  logic signed [ams_pkg::WORD_BITS-1:0] divisor,
   output logic                                done,
   output logic signed [ams_pkg::WORD_BITS-1:0] quotient
);
   import ams_pkg::*;

   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [WORD_BITS-1:0] rem_ff, rem_in;
   logic [WORD_BITS-1:0] quo_ff, quo_in;
   logic [WORD_BITS-1:0] magb_ff, magb_in;
   logic                 neg_ff, neg_in;
   logic [WORD_BITS:0]   rem_shift;
   logic [WORD_BITS:0]   diff;
   logic                 fits;
   logic [WORD_BITS-1:0] mag_a;
   logic [WORD_BITS-1:0] mag_b;

   // magnitudes fit unsigned, the most negative value included
   assign mag_a = dividend[WORD_BITS-1] ? WORD_BITS'(-dividend) : WORD_BITS'(dividend);
   assign mag_b = divisor[WORD_BITS-1] ? WORD_BITS'(-divisor) : WORD_BITS'(divisor);

   assign rem_shift = {rem_ff, quo_ff[WORD_BITS-1]};
   assign diff      = rem_shift - {1'b0, magb_ff};
   assign fits      = !diff[WORD_BITS];

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      magb_in = magb_ff;
      neg_in  = neg_ff;
      if (start) begin
         cnt_in  = CNT_BITS'(WORD_BITS);
         rem_in  = '0;
         quo_in  = mag_a;
         magb_in = mag_b;
         neg_in  = dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
      end else if (cnt_ff != '0) begin
         // restoring step, one quotient bit
         rem_in  = fits ? diff[WORD_BITS-1:0] : rem_shift[WORD_BITS-1:0];
         quo_in  = {quo_ff[WORD_BITS-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      magb_ff <= magb_in;
      neg_ff  <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? WORD_BITS'(-quo_ff) : WORD_BITS'(quo_ff);

endmodule

[rtl/ams_dpath.sv]
module ams_dpath (
   input  logic             clock,
   input  logic             reset,
   input  ams_pkg::req_type req_data,
   input  ams_pkg::cmd_type cmd,
   output ams_pkg::sts_type sts,
   output ams_pkg::rsp_type rsp_data
);
   import ams_pkg::*;

   req_type              item_ff, item_in;
   rsp_type              rsp_ff, rsp_in;

   logic [WORD_BITS-1:0] mem_ff [MEM_WORDS];
   logic [MEM_WORDS-1:0] mem_valid_ff;
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rd_valid_ff;
   logic                 rd_en;
   logic [ADDR_BITS-1:0] rd_addr;
   logic                 wr_en;
   logic [ADDR_BITS-1:0] wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   logic signed [WORD_BITS-1:0] acc_ff, acc_in;
   logic [ADDR_BITS-1:0]        pc_ff, pc_in;
   logic                        halt_ff, halt_in;
   logic [1:0]                  status_ff, status_in;
   logic                        ovalid_ff, ovalid_in;
   logic [WORD_BITS-1:0]        oval_ff, oval_in;
   logic                        used_ff, used_in;
   logic [OP_BITS-1:0]          op_ff, op_in;
   logic [ADDR_BITS-1:0]        addr_ff, addr_in;
   logic                        unknown_ff, unknown_in;
   logic [WORD_BITS-1:0]        product_ff;

   logic signed [WORD_BITS-1:0]        m_word;
   logic                               m_zero;
   logic [ADDR_BITS-1:0]               seq_pc;
   logic                               dec_in_range;
   logic [DEC_BITS-1:0]                dec_w;
   logic [DEC_BITS+RECIP_BITS-1:0]     dec_prod;
   logic [OP_BITS-1:0]                 dec_q;
   logic [DEC_BITS:0]                  dec_r;
   logic                               div_done;
   logic signed [WORD_BITS-1:0]        div_quotient;

   // never-written entries read as zero
   assign m_word = rd_valid_ff ? rd_data_ff : '0;
   assign m_zero = (m_word == '0);
   assign seq_pc = (pc_ff >= ADDR_BITS'(MEM_WORDS - 1)) ? '0 : pc_ff + 1'b1;

   // opcode and address by reciprocal multiply with one correction
   assign dec_in_range = !m_word[WORD_BITS-1]
                         && (m_word >= WORD_BITS'(DEC_LOW))
                         && (m_word < WORD_BITS'(DEC_HIGH));
   assign dec_w    = m_word[DEC_BITS-1:0];
   assign dec_prod = (DEC_BITS+RECIP_BITS)'(dec_w) * (DEC_BITS+RECIP_BITS)'(RECIP);
   assign dec_q    = dec_prod[RECIP_SHIFT +: OP_BITS];
   assign dec_r    = (DEC_BITS+1)'(dec_w) - (DEC_BITS+1)'(dec_q) * (DEC_BITS+1)'(DEC_RADIX);

   always_comb begin
      op_in      = op_ff;
      addr_in    = addr_ff;
      unknown_in = unknown_ff;
      if (cmd.decode) begin
         unknown_in = !dec_in_range;
         if (dec_r >= (DEC_BITS+1)'(DEC_RADIX)) begin
            op_in   = dec_q + 1'b1;
            addr_in = ADDR_BITS'(dec_r - (DEC_BITS+1)'(DEC_RADIX));
         end else begin
            op_in   = dec_q;
            addr_in = ADDR_BITS'(dec_r);
         end
         if (!dec_in_range) begin
            addr_in = '0;
         end
      end
   end

   always_comb begin
      acc_in    = acc_ff;
      pc_in     = pc_ff;
      halt_in   = halt_ff;
      status_in = status_ff;
      ovalid_in = ovalid_ff;
      oval_in   = oval_ff;
      used_in   = used_ff;
      wr_en     = 1'b0;
      wr_addr   = addr_ff;
      wr_data   = WORD_BITS'(acc_ff);
      item_in   = item_ff;

      if (cmd.capture) begin
         item_in   = req_data;
         status_in = ST_OK;
         ovalid_in = 1'b0;
         oval_in   = '0;
         used_in   = 1'b0;
      end
      if (cmd.load_write && (item_ff.load_address < ADDR_BITS'(MEM_WORDS))) begin
         wr_en   = 1'b1;
         wr_addr = item_ff.load_address;
         wr_data = WORD_BITS'(item_ff.load_word);
      end
      if (cmd.restart) begin
         pc_in   = '0;
         acc_in  = '0;
         halt_in = 1'b0;
      end
      if (cmd.ignore) begin
         status_in = ST_HALTED;
      end
      if (cmd.exec) begin
         pc_in = seq_pc;
         if (unknown_ff) begin
            status_in = ST_UNKNOWN;
         end else begin
            case (op_ff)
               OP_READ: begin
                  wr_en   = 1'b1;
                  wr_data = WORD_BITS'(item_ff.input_value);
                  used_in = 1'b1;
               end
               OP_WRITE: begin
                  ovalid_in = 1'b1;
                  oval_in   = m_word;
               end
               OP_LOAD:  acc_in = m_word;
               OP_STORE: wr_en = 1'b1;
               OP_ADD:   acc_in = acc_ff + m_word;
               OP_SUB:   acc_in = acc_ff - m_word;
               OP_DIV: begin
                  if (m_zero) begin
                     status_in = ST_DIV_ZERO;
                  end
               end
               OP_MUL:   ;
               OP_BRANCH: pc_in = addr_ff;
               OP_BRNEG: begin
                  if (acc_ff[WORD_BITS-1]) begin
                     pc_in = addr_ff;
                  end
               end
               OP_BRZERO: begin
                  if (acc_ff == '0) begin
                     pc_in = addr_ff;
                  end
               end
               OP_HALT: begin
                  halt_in = 1'b1;
                  pc_in   = pc_ff;
               end
               default: status_in = ST_UNKNOWN;
            endcase
         end
      end
      if (cmd.mul_wb) begin
         acc_in = product_ff;
      end
      if (cmd.div_wb) begin
         acc_in = div_quotient;
      end
   end

   always_comb begin
      rsp_in            = rsp_ff;
      if (cmd.rsp_load) begin
         rsp_in.pc         = pc_ff;
         rsp_in.acc_value  = 32'(acc_ff);
         rsp_in.out_valid  = ovalid_ff;
         rsp_in.out_value  = 32'(oval_ff);
         rsp_in.input_used = used_ff;
         rsp_in.halted     = halt_ff;
         rsp_in.status     = status_ff;
      end
   end

   assign rd_en   = cmd.rd_pc | cmd.rd_addr;
   assign rd_addr = cmd.rd_pc ? pc_ff : addr_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
         acc_ff       <= '0;
         pc_ff        <= '0;
         halt_ff      <= 1'b0;
      end else begin
         if (wr_en) begin
            mem_valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= mem_valid_ff[rd_addr];
         end
         acc_ff  <= acc_in;
         pc_ff   <= pc_in;
         halt_ff <= halt_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      rsp_ff     <= rsp_in;
      status_ff  <= status_in;
      ovalid_ff  <= ovalid_in;
      oval_ff    <= oval_in;
      used_ff    <= used_in;
      op_ff      <= op_in;
      addr_ff    <= addr_in;
      unknown_ff <= unknown_in;
      product_ff <= WORD_BITS'(acc_ff * m_word);
   end

   ams_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (acc_ff),
      .divisor  (m_word),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign sts.kind     = item_ff.kind;
   assign sts.halted   = halt_ff;
   assign sts.div_go   = !unknown_ff && (op_ff == OP_DIV) && !m_zero;
   assign sts.mul_go   = !unknown_ff && (op_ff == OP_MUL);
   assign sts.div_done = div_done;

   assign rsp_data = rsp_ff;

endmodule

[rtl/ams_ctrl.sv]
module ams_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  ams_pkg::sts_type sts,
   output ams_pkg::cmd_type cmd
);
   import ams_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DISPATCH = 3'd1;
   localparam logic [2:0] S_DECODE   = 3'd2;
   localparam logic [2:0] S_OPER     = 3'd3;
   localparam logic [2:0] S_EXEC     = 3'd4;
   localparam logic [2:0] S_MUL      = 3'd5;
   localparam logic [2:0] S_DIV      = 3'd6;
   localparam logic [2:0] S_DONE     = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_DONE;
            case (sts.kind)
               KIND_LOAD:    cmd.load_write = 1'b1;
               KIND_RESTART: cmd.restart = 1'b1;
               KIND_EXEC: begin
                  if (sts.halted) begin
                     cmd.ignore = 1'b1;
                  end else begin
                     // fetch the instruction word
                     cmd.rd_pc = 1'b1;
                     state_in  = S_DECODE;
                  end
               end
               default: ;
            endcase
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = S_OPER;
         end
         S_OPER: begin
            cmd.rd_addr = 1'b1;
            state_in    = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (sts.div_go) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else if (sts.mul_go) begin
               state_in = S_MUL;
            end else begin
               state_in = S_DONE;
            end
         end
         S_MUL: begin
            cmd.mul_wb = 1'b1;
            state_in   = S_DONE;
         end
         S_DIV: begin
            if (sts.div_done) begin
               cmd.div_wb = 1'b1;
               state_in   = S_DONE;
            end
         end
         S_DONE: begin
            // result register free or emptied by this transfer
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/accumulator_machine_step.sv]
// load, restart and halted steps pass dispatch and done; instructions add decode,
// operand read and execute, multiply a write-back state, and divide the wait on the
// 32-step restoring divider (one quotient bit per cycle).
// one item at a time; a new request is taken from the cycle after the result is
// registered, even while that result still waits for its transfer.
// reset clears pc, accumulator, halt flag and the per-word valid bits of memory.
module accumulator_machine_step (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ams_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ams_pkg::rsp_type rsp_data
);
   import ams_pkg::*;

   cmd_type cmd;
   sts_type sts;

   ams_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ams_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

[rtl/ams_checker.sv]
module ams_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ams_pkg::rsp_type rsp_data
);
   import ams_pkg::*;

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.pc < ADDR_BITS'(MEM_WORDS))
      else $error("pc out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.out_valid |-> rsp_data.out_value == '0)
      else $error("emitted value without write");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.out_valid || rsp_data.input_used)
         |-> rsp_data.status == ST_OK && !(rsp_data.out_valid && rsp_data.input_used))
      else $error("inconsistent write/read flags");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_HALTED |-> rsp_data.halted)
      else $error("ignored step without halt flag");

endmodule

bind accumulator_machine_step ams_checker u_checker (.*);

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import ams_pkg::*;

   localparam int RESET_CYCLES     = 8;
   localparam int RANDOM_ITEMS     = 1200;
   localparam int QUIET_ITEMS      = 120;
   localparam int DRAIN_EVERY      = 30;
   localparam int LONG_HOLD_AT     = 300;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int SETTLE_CYCLES    = 60;
   localparam int REPORT_LIMIT     = 50;

   // the fourth kind code has no meaning and must leave the machine alone
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   typedef struct {
      req_type item;
      bit      wait_drain;
   } queued_item_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   queued_item_type program_items[$];
   rsp_type         expected_outcomes[$];

   // machine state as the predictor sees it
   logic signed [31:0]    prog_mem [0:MEM_WORDS-1];
   logic signed [31:0]    acc_reg;
   logic [ADDR_BITS-1:0]  pc_reg;
   logic                  halt_reg;

   int   mismatch_count = 0;
   int   stimulus_items = 0;
   bit   drain_next     = 1'b0;
   logic quiet_phase    = 1'b0;
   int   send_gap       = 0;
   int   hold_left      = 0;
   int   outcomes_seen  = 0;
   bit   long_hold_done = 1'b0;

   accumulator_machine_step DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(string what);
      if (mismatch_count < REPORT_LIMIT) begin
         $display("%0t: %s", $time, what);
      end
      mismatch_count++;
   endtask

   function automatic logic signed [31:0] encode(logic [OP_BITS-1:0] op, int target);
      return op * DEC_RADIX + target;
   endfunction

   function automatic logic signed [31:0] pick_data();
      case ($urandom_range(0, 7))
         0: return 32'sd0;
         1: return 32'sd1;
         2: return -32'sd1;
         3: return 32'sh80000000;
         4: return 32'sh7fffffff;
         5: return $urandom_range(0, 200) - 100;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [31:0] random_instruction(int base, int len);
      logic [OP_BITS-1:0] op;
      int target;
      case ($urandom_range(0, 13))
         0: op = OP_READ;
         1: op = OP_WRITE;
         2: op = OP_LOAD;
         3: op = OP_STORE;
         4: op = OP_ADD;
         5: op = OP_SUB;
         6: op = OP_DIV;
         7: op = OP_MUL;
         8: op = OP_BRANCH;
         9: op = OP_BRNEG;
         10: op = OP_BRZERO;
         11: op = OP_HALT;
         12: return $urandom_range(0, 99999);
         default: return $urandom;
      endcase
      // keep branches inside the program so runs stay long
      if (op == OP_BRANCH || op == OP_BRNEG || op == OP_BRZERO) begin
         target = (base + $urandom_range(0, len - 1)) % MEM_WORDS;
      end else begin
         target = $urandom_range(0, MEM_WORDS - 1);
      end
      return encode(op, target);
   endfunction

   task automatic add_item(logic [1:0] kind, int address, logic signed [31:0] word,
                           logic signed [31:0] value);
      queued_item_type entry;
      entry.item.kind         = kind;
      entry.item.load_address = ADDR_BITS'(address);
      entry.item.load_word    = word;
      entry.item.input_value  = value;
      entry.wait_drain        = drain_next;
      drain_next              = 1'b0;
      program_items.push_back(entry);
      if (kind != KIND_UNUSED && !(kind == KIND_LOAD && address >= MEM_WORDS)) begin
         stimulus_items++;
      end
   endtask

   // one item through the machine: updates the state and returns the snapshot
   function automatic rsp_type run_machine_item(req_type item);
      rsp_type            result;
      logic signed [31:0] word;
      logic signed [31:0] operand;
      int                 opcode;
      int                 target;
      logic [ADDR_BITS-1:0] next_pc;
      result = '0;
      case (item.kind)
         KIND_LOAD: begin
            if (item.load_address < MEM_WORDS) begin
               prog_mem[item.load_address] = item.load_word;
            end
         end
         KIND_RESTART: begin
            pc_reg   = '0;
            acc_reg  = '0;
            halt_reg = 1'b0;
         end
         KIND_EXEC: begin
            if (halt_reg) begin
               result.status = ST_HALTED;
            end else begin
               word    = prog_mem[pc_reg];
               opcode  = (word < 0) ? -1 : word / DEC_RADIX;
               target  = (word < 0) ? 0 : word % DEC_RADIX;
               operand = prog_mem[target];
               next_pc = (pc_reg == MEM_WORDS - 1) ? '0 : pc_reg + 1'b1;
               case (opcode)
                  OP_READ: begin
                     prog_mem[target]  = item.input_value;
                     result.input_used = 1'b1;
                  end
                  OP_WRITE: begin
                     result.out_valid = 1'b1;
                     result.out_value = operand;
                  end
                  OP_LOAD:  acc_reg = operand;
                  OP_STORE: prog_mem[target] = acc_reg;
                  OP_ADD:   acc_reg = acc_reg + operand;
                  OP_SUB:   acc_reg = acc_reg - operand;
                  OP_DIV: begin
                     if (operand == 0) begin
                        result.status = ST_DIV_ZERO;
                     end else if (operand == -1) begin
                        // most negative over minus one wraps back to itself
                        acc_reg = -acc_reg;
                     end else begin
                        acc_reg = acc_reg / operand;
                     end
                  end
                  OP_MUL:    acc_reg = acc_reg * operand;
                  OP_BRANCH: next_pc = ADDR_BITS'(target);
                  OP_BRNEG: begin
                     if (acc_reg < 0) begin
                        next_pc = ADDR_BITS'(target);
                     end
                  end
                  OP_BRZERO: begin
                     if (acc_reg == 0) begin
                        next_pc = ADDR_BITS'(target);
                     end
                  end
                  OP_HALT: begin
                     halt_reg = 1'b1;
                     next_pc  = pc_reg;
                  end
                  default: result.status = ST_UNKNOWN;
               endcase
               pc_reg = next_pc;
            end
         end
         default: ;
      endcase
      result.pc        = pc_reg;
      result.acc_value = acc_reg;
      result.halted    = halt_reg;
      return result;
   endfunction

   task automatic check_outcome(rsp_type got);
      rsp_type want;
      if (expected_outcomes.size() == 0) begin
         report_mismatch($sformatf("result with no item outstanding, pc %0d", got.pc));
         return;
      end
      want = expected_outcomes.pop_front();
      if (got.pc !== want.pc)
         report_mismatch($sformatf("pc: got %0d, expected %0d", got.pc, want.pc));
      if (got.acc_value !== want.acc_value)
         report_mismatch($sformatf("acc_value: got %0d, expected %0d",
                                   got.acc_value, want.acc_value));
      if (got.out_valid !== want.out_valid)
         report_mismatch($sformatf("out_valid: got %0d, expected %0d",
                                   got.out_valid, want.out_valid));
      if (got.out_value !== want.out_value)
         report_mismatch($sformatf("out_value: got %0d, expected %0d",
                                   got.out_value, want.out_value));
      if (got.input_used !== want.input_used)
         report_mismatch($sformatf("input_used: got %0d, expected %0d",
                                   got.input_used, want.input_used));
      if (got.halted !== want.halted)
         report_mismatch($sformatf("halted: got %0d, expected %0d", got.halted, want.halted));
      if (got.status !== want.status)
         report_mismatch($sformatf("status: got %0d, expected %0d", got.status, want.status));
   endtask

   // request side
   always @(posedge clock) begin : driver
      queued_item_type entry;
      if (reset) begin
         req_valid   <= 1'b0;
         quiet_phase <= 1'b0;
         send_gap     = 0;
         for (int i = 0; i < MEM_WORDS; i++) begin
            prog_mem[i] = '0;
         end
         acc_reg  = '0;
         pc_reg   = '0;
         halt_reg = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_outcomes.push_back(run_machine_item(req_data));
            if (!quiet_phase && $urandom_range(0, 4) == 0) begin
               send_gap = $urandom_range(1, 13);
            end
         end
         if (!(req_valid && !req_ready)) begin
            if (send_gap != 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (program_items.size() != 0 &&
                         !(program_items[0].wait_drain && expected_outcomes.size() != 0)) begin
               entry = program_items.pop_front();
               req_data  <= entry.item;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         quiet_phase <= (program_items.size() < QUIET_ITEMS);
      end
   end

   // result side
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left  = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_outcome(rsp_data);
            outcomes_seen++;
         end
         if (hold_left != 0) begin
            hold_left--;
         end else if (outcomes_seen >= LONG_HOLD_AT && !long_hold_done) begin
            // long back-pressure so the block fills and stops taking requests
            hold_left      = LONG_HOLD_CYCLES;
            long_hold_done = 1'b1;
         end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
            hold_left = $urandom_range(1, 13);
         end
         rsp_ready <= (hold_left == 0);
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin : stimulus
      int base;
      int len;
      int episode;

      // hand-written program: every opcode, wrap past 99, halt and restart
      add_item(KIND_LOAD, 0, encode(OP_BRANCH, 90), 0);
      add_item(KIND_LOAD, 90, encode(OP_READ, 60), 0);
      add_item(KIND_LOAD, 91, encode(OP_LOAD, 60), 0);
      add_item(KIND_LOAD, 92, encode(OP_DIV, 95), 0);
      add_item(KIND_LOAD, 93, encode(OP_MUL, 95), 0);
      add_item(KIND_LOAD, 94, encode(OP_DIV, 89), 0);
      add_item(KIND_LOAD, 95, -32'sd1, 0);
      add_item(KIND_LOAD, 96, encode(OP_BRNEG, 98), 0);
      add_item(KIND_LOAD, 98, encode(OP_STORE, 0), 0);
      add_item(KIND_LOAD, 99, encode(OP_WRITE, 60), 0);
      add_item(KIND_LOAD, 1, encode(OP_SUB, 60), 0);
      add_item(KIND_LOAD, 2, encode(OP_BRZERO, 4), 0);
      add_item(KIND_LOAD, 4, encode(OP_ADD, 99), 0);
      add_item(KIND_LOAD, 5, encode(OP_HALT, 0), 0);
      add_item(KIND_EXEC, 0, 0, 0);
      add_item(KIND_EXEC, 0, 0, 32'sh80000000);
      repeat (14) add_item(KIND_EXEC, $urandom_range(0, 127), $urandom, $urandom);
      add_item(KIND_UNUSED, 127, 32'sh7fffffff, 32'sh7fffffff);
      add_item(KIND_LOAD, 127, 32'sh7fffffff, 0);
      add_item(KIND_RESTART, 0, 0, 0);

      stimulus_items = 0;
      episode = 0;
      while (stimulus_items < RANDOM_ITEMS) begin
         if (episode % DRAIN_EVERY == 0) begin
            drain_next = 1'b1;
         end
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4)) begin
               case ($urandom_range(0, 3))
                  0: add_item(KIND_UNUSED, $urandom_range(0, 127), $urandom, $urandom);
                  1: add_item(KIND_LOAD, $urandom_range(MEM_WORDS, 127), $urandom, $urandom);
                  2: add_item(KIND_LOAD, $urandom_range(0, MEM_WORDS - 1), $urandom, $urandom);
                  default: add_item(KIND_EXEC, $urandom_range(0, 127), $urandom, $urandom);
               endcase
            end
         end else begin
            len  = $urandom_range(2, 12);
            base = ($urandom_range(0, 2) == 0) ? $urandom_range(1, MEM_WORDS - 1) : 0;
            if ($urandom_range(0, 4) != 0) begin
               add_item(KIND_RESTART, $urandom_range(0, 127), $urandom, $urandom);
            end
            for (int i = 0; i < len; i++) begin
               add_item(KIND_LOAD, (base + i) % MEM_WORDS, random_instruction(base, len),
                        $urandom);
            end
            if (base != 0) begin
               add_item(KIND_LOAD, 0, encode(OP_BRANCH, base), $urandom);
            end
            repeat ($urandom_range(1, 4)) begin
               add_item(KIND_LOAD, $urandom_range(0, MEM_WORDS - 1), pick_data(), $urandom);
            end
            repeat (len + $urandom_range(0, 6)) begin
               add_item(KIND_EXEC, $urandom_range(0, 127), $urandom, pick_data());
            end
         end
         episode++;
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (program_items.size() != 0 || req_valid || expected_outcomes.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_outcomes.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", expected_outcomes.size()));
      end
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
